>>> rtl/core/pps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants of the particle pool stepper
// Pool depth, field widths and the command/status words that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package pps_pkg;

	// pool geometry
	localparam int POOL_SLOTS = 64;
	localparam int IDX_W      = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int CNT_W      = $clog2(POOL_SLOTS + 1);

	// fixed field widths
	localparam int POS_W  = 26;
	localparam int VEL_W  = 15;
	localparam int LIFE_W = 16;
	localparam int TINT_W = 16;
	localparam int SLOT_W = 6;
	localparam int TOT_W  = 7;

	// report kinds
	localparam logic [1:0] RK_ADD   = 2'd0;
	localparam logic [1:0] RK_LIVE  = 2'd1;
	localparam logic [1:0] RK_EMPTY = 2'd2;

	// controller -> datapath commands
	typedef struct packed {
		logic load;        // latch input word
		logic cnt_clr;     // restart slot counter and report count
		logic cnt_step;    // advance slot counter
		logic add_commit;  // store latched particle at counter slot
		logic emit_reject; // answer a rejected add
		logic emit_empty;  // answer a tick with nothing live
		logic upd_issue;   // read counter slot for the update pass
		logic rep_issue;   // read counter slot for the report pass
	} pps_cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic full;        // every slot busy
		logic cnt_last;    // counter at the final slot
		logic slot_free;   // slot at the counter is free
		logic count_zero;  // nothing live
	} pps_stat_t;

endpackage

>>> rtl/core/particle_pool_stepper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_pool_stepper_core: fixed pool of moving particles
// A word is taken when start is high and busy is low. kind 0 adds a particle
// to the lowest free slot and gives one answer. kind 1 ticks the pool: each
// live particle moves by its velocity with saturation and counts down, or is
// freed when its lifetime is zero; then every live particle is reported in
// slot order, the final one marked by last, or one empty report is given.
// Each result is given on the result ports, marked by result_strobe for
// exactly one cycle; the receiver cannot hold results off. An add to a
// full pool answers in the cycle after the word is taken and leaves busy low;
// otherwise an add keeps busy high while it scans up from slot 0 to the slot
// it lands in. A tick keeps busy high while the single read port of the slot
// memory is swept once for the update pass and, unless no particle survives,
// once for the report pass.
// ----------------------------------------------------------------------------
module particle_pool_stepper_core
	import pps_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     kind,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [VEL_W-1:0]  vel_x,
	input  logic signed [VEL_W-1:0]  vel_y,
	input  logic [LIFE_W-1:0]        lifetime,
	input  logic [TINT_W-1:0]        tint,
	output logic                     result_strobe,
	output logic [1:0]               report_kind,
	output logic                     accepted,
	output logic [SLOT_W-1:0]        slot,
	output logic signed [POS_W-1:0]  out_x,
	output logic signed [POS_W-1:0]  out_y,
	output logic [TINT_W-1:0]        out_tint,
	output logic [TOT_W-1:0]         live_total,
	output logic                     last
);

	pps_cmd_t  cmd;
	pps_stat_t stat;

	// sequencer
	pps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// slot store and arithmetic
	pps_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.vel_x         (vel_x),
		.vel_y         (vel_y),
		.lifetime      (lifetime),
		.tint          (tint),
		.result_strobe (result_strobe),
		.report_kind   (report_kind),
		.accepted      (accepted),
		.slot          (slot),
		.out_x         (out_x),
		.out_y         (out_y),
		.out_tint      (out_tint),
		.live_total    (live_total),
		.last          (last)
	);

endmodule

>>> rtl/core/pps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_ctrl: sequencer of the particle pool stepper
// Decodes accepted words and steps the datapath through the free slot scan
// of an add, or the update pass and report pass of a tick.
// ----------------------------------------------------------------------------
module pps_ctrl
	import pps_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      kind,
	input  pps_stat_t stat,
	output pps_cmd_t  cmd,
	output logic      busy
);

	typedef enum logic [6:0] {
		ST_IDLE      = 7'b0000001,
		ST_ADD_SCAN  = 7'b0000010,
		ST_UPD       = 7'b0000100,
		ST_UPD_DRAIN = 7'b0001000,
		ST_CHK       = 7'b0010000,
		ST_REP       = 7'b0100000,
		ST_REP_DRAIN = 7'b1000000
	} pps_state_t;

	pps_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load    = 1'b1;
					cmd.cnt_clr = 1'b1;
					if (!kind) begin
						if (stat.full) begin
							cmd.emit_reject = 1'b1;
						end else begin
							state_d = ST_ADD_SCAN;
						end
					end else begin
						state_d = ST_UPD;
					end
				end
			end
			ST_ADD_SCAN: begin
				if (stat.slot_free) begin
					cmd.add_commit = 1'b1;
					state_d        = ST_IDLE;
				end else begin
					cmd.cnt_step = 1'b1;
				end
			end
			ST_UPD: begin
				cmd.upd_issue = 1'b1;
				cmd.cnt_step  = 1'b1;
				if (stat.cnt_last) begin
					state_d = ST_UPD_DRAIN;
				end
			end
			ST_UPD_DRAIN: begin
				state_d = ST_CHK;
			end
			ST_CHK: begin
				cmd.cnt_clr = 1'b1;
				if (stat.count_zero) begin
					cmd.emit_empty = 1'b1;
					state_d        = ST_IDLE;
				end else begin
					state_d = ST_REP;
				end
			end
			ST_REP: begin
				cmd.rep_issue = 1'b1;
				cmd.cnt_step  = 1'b1;
				if (stat.cnt_last) begin
					state_d = ST_REP_DRAIN;
				end
			end
			ST_REP_DRAIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

>>> rtl/core/pps_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_dpath: slot store and arithmetic of the particle pool stepper
// Holds the slot memory, busy flags and live count, runs the one-slot-per-
// cycle read/modify/write pipeline and drives the result registers.
// ----------------------------------------------------------------------------
module pps_dpath
	import pps_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  pps_cmd_t                 cmd,
	output pps_stat_t                stat,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [VEL_W-1:0]  vel_x,
	input  logic signed [VEL_W-1:0]  vel_y,
	input  logic [LIFE_W-1:0]        lifetime,
	input  logic [TINT_W-1:0]        tint,
	output logic                     result_strobe,
	output logic [1:0]               report_kind,
	output logic                     accepted,
	output logic [SLOT_W-1:0]        slot,
	output logic signed [POS_W-1:0]  out_x,
	output logic signed [POS_W-1:0]  out_y,
	output logic [TINT_W-1:0]        out_tint,
	output logic [TOT_W-1:0]         live_total,
	output logic                     last
);

	typedef struct packed {
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [VEL_W-1:0]  vx;
		logic [VEL_W-1:0]  vy;
		logic [LIFE_W-1:0] life;
		logic [TINT_W-1:0] tint;
	} slot_word_t;

	// saturating position step
	function automatic logic [POS_W-1:0] sat_step(input logic [POS_W-1:0] p,
	                                               input logic [VEL_W-1:0] v);
		logic [POS_W:0] s;
		s = {p[POS_W-1], p} + {{(POS_W-VEL_W+1){v[VEL_W-1]}}, v};
		if (s[POS_W] != s[POS_W-1]) begin
			sat_step = s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
		end else begin
			sat_step = s[POS_W-1:0];
		end
	endfunction

	// latched add word
	slot_word_t in_word_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_word_q.x    <= pos_x;
			in_word_q.y    <= pos_y;
			in_word_q.vx   <= vel_x;
			in_word_q.vy   <= vel_y;
			in_word_q.life <= lifetime;
			in_word_q.tint <= tint;
		end
	end

	// slot counter
	logic [IDX_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// slot memory, registered read at the counter slot
	slot_word_t       slot_mem [POOL_SLOTS];
	slot_word_t       rd_word_s1;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	slot_word_t       mem_wdata;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_waddr] <= mem_wdata;
		end
		rd_word_s1 <= slot_mem[cnt_q];
	end

	// stage 1 control
	logic             vld_s1;
	logic             rep_s1;
	logic [IDX_W-1:0] addr_s1;
	logic [POOL_SLOTS-1:0] busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			rep_s1 <= 1'b0;
		end else begin
			vld_s1 <= (cmd.upd_issue || cmd.rep_issue) && busy_q[cnt_q];
			rep_s1 <= cmd.rep_issue;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q;
	end

	// update of one live slot
	logic       life_nz;
	logic       upd_we;
	logic       upd_free;
	logic       rep_emit;
	slot_word_t upd_word;

	always_comb begin
		life_nz       = (rd_word_s1.life != '0);
		upd_word      = rd_word_s1;
		upd_word.x    = sat_step(rd_word_s1.x, rd_word_s1.vx);
		upd_word.y    = sat_step(rd_word_s1.y, rd_word_s1.vy);
		upd_word.life = rd_word_s1.life - 1'b1;
		upd_we        = vld_s1 && !rep_s1 && life_nz;
		upd_free      = vld_s1 && !rep_s1 && !life_nz;
		rep_emit      = vld_s1 && rep_s1;
	end

	// write port select
	always_comb begin
		mem_we    = cmd.add_commit || upd_we;
		mem_waddr = cmd.add_commit ? cnt_q : addr_s1;
		mem_wdata = cmd.add_commit ? in_word_q : upd_word;
	end

	// busy flags and live count
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.add_commit) begin
				busy_q[cnt_q] <= 1'b1;
				count_q       <= count_q + 1'b1;
			end else if (upd_free) begin
				busy_q[addr_s1] <= 1'b0;
				count_q         <= count_q - 1'b1;
			end
		end
	end

	// reports given so far in this tick
	logic [CNT_W-1:0] rep_cnt_q;
	logic [CNT_W-1:0] rep_next;

	assign rep_next = rep_cnt_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			rep_cnt_q <= '0;
		end else if (rep_emit) begin
			rep_cnt_q <= rep_next;
		end
	end

	// status
	always_comb begin
		stat.full       = (count_q == CNT_W'(POOL_SLOTS));
		stat.cnt_last   = (cnt_q == IDX_W'(POOL_SLOTS - 1));
		stat.slot_free  = !busy_q[cnt_q];
		stat.count_zero = (count_q == '0);
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= cmd.emit_reject || cmd.add_commit || cmd.emit_empty || rep_emit;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (cmd.emit_reject || cmd.add_commit) begin
			report_kind <= RK_ADD;
			accepted    <= cmd.add_commit;
			slot        <= cmd.add_commit ? SLOT_W'(cnt_q) : '0;
			out_x       <= '0;
			out_y       <= '0;
			out_tint    <= '0;
			live_total  <= cmd.add_commit ? TOT_W'(count_q + 1'b1) : TOT_W'(count_q);
			last        <= 1'b1;
		end else if (cmd.emit_empty) begin
			report_kind <= RK_EMPTY;
			accepted    <= 1'b0;
			slot        <= '0;
			out_x       <= '0;
			out_y       <= '0;
			out_tint    <= '0;
			live_total  <= '0;
			last        <= 1'b1;
		end else if (rep_emit) begin
			report_kind <= RK_LIVE;
			accepted    <= 1'b0;
			slot        <= SLOT_W'(addr_s1);
			out_x       <= rd_word_s1.x;
			out_y       <= rd_word_s1.y;
			out_tint    <= rd_word_s1.tint;
			live_total  <= TOT_W'(count_q);
			last        <= (rep_next == count_q);
		end
	end

	// checks
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(busy_q)))
		else $error("live count differs from busy flags");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_commit |-> !busy_q[cnt_q])
		else $error("add stored into a busy slot");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.add_commit && (upd_we || upd_free)))
		else $error("add collides with update pass");

	a_report_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rep_emit |-> (rep_cnt_q < count_q))
		else $error("more reports than live particles");

endmodule
